// ----- rtl/mips_subset_execute_assert.svh -----
// Assertion macros shared by the execute block RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef MIPS_SUBSET_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_ASSERT_SVH

// Checked at every edge outside reset.
`define MSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/mse_pkg.sv -----
// Package of the MIPS subset execute block: constants, opcodes, types.
// No dependencies.
package mse_pkg;

   localparam int DATA_WORDS = 65536;
   localparam int ADDR_W     = $clog2(DATA_WORDS);

   localparam logic [31:0] DATA_BASE    = 32'h1000_0000;
   localparam logic [31:0] GP_INIT      = 32'h1000_8000;
   localparam logic [31:0] SP_INIT      = 32'(64'(DATA_BASE) + 64'(DATA_WORDS) * 64'd4);
   localparam logic [31:0] DATA_BYTES   = 32'(64'(DATA_WORDS) * 64'd4);
   localparam logic [31:0] START_PC_RST = 32'h0040_0000;
   localparam logic [31:0] JUMP_MASK    = 32'hf000_0000;

   localparam logic [4:0] REG_GP = 5'd28;
   localparam logic [4:0] REG_SP = 5'd29;
   localparam logic [4:0] REG_RA = 5'd31;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_TRAP    = 6'h1a;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2b;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1a;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_SLT  = 6'h2a;

   localparam logic [3:0] TRAP_NEWLINE = 4'h0;
   localparam logic [3:0] TRAP_PRINT   = 4'h1;
   localparam logic [3:0] TRAP_READ    = 4'h5;
   localparam logic [3:0] TRAP_HALT    = 4'ha;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_NEWLINE = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;
   localparam logic [1:0] KIND_PROMPT  = 2'd3;

   localparam logic [2:0] STAT_RUN   = 3'd0;
   localparam logic [2:0] STAT_HALT  = 3'd1;
   localparam logic [2:0] STAT_DIVZ  = 3'd2;
   localparam logic [2:0] STAT_BADI  = 3'd3;
   localparam logic [2:0] STAT_BADT  = 3'd4;
   localparam logic [2:0] STAT_UNAL  = 3'd5;
   localparam logic [2:0] STAT_RANGE = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MEM,
      S_DIV,
      S_WB
   } state_type;

   typedef struct packed {
      logic              reg_we;
      logic [4:0]        reg_addr;
      logic [31:0]       reg_data;
      logic              hilo_we;
      logic [31:0]       hi;
      logic [31:0]       lo;
      logic              mem_we;
      logic [ADDR_W-1:0] mem_idx;
      logic [31:0]       mem_data;
      logic [31:0]       pc;
      logic [1:0]        kind;
      logic [31:0]       pval;
      logic [2:0]        st;
   } wb_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [31:0] rem;
   } div_out_type;

endpackage

// ----- rtl/mips_subset_execute.sv -----
// Usage of the MIPS subset execute block.
// One item on the req_ channel is an instruction word fetched at the pc that the
// previous result reported (or start_pc), plus a value for the read trap.
// Each item gives exactly one result item on the rsp_ channel: the next pc,
// a print action with its value, and a status (0 while running).
// The block works on one item at a time. When an item is taken, its
// register operands are read from the register file memory into registers;
// the execute state works out the result, which the writeback state moves
// to the output register. An lw adds a state for the data memory read port,
// and a div adds the iterative divider (one quotient bit per cycle).
// A finished result waits in the output register while rsp_ready is low;
// the block then holds its writeback and takes no new item until it drains.
// After reset the data memory is cleared by a sweep over all DATA_WORDS words
// (65536 at the default) during which req_ready stays low; csr_ writes load
// the program counter, except when a result is written back, whose pc then wins.
// Once an error or the halt trap is reported, every later item gets the same
// status until the next reset, and the same pc until a csr_ write loads a new one.
// Depends on mse_pkg, mse_regfile, mse_dmem, mse_divider and the assert header.
`include "mips_subset_execute_assert.svh"
module mips_subset_execute import mse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_word,
   input  logic signed [31:0] req_trap_input,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_next_pc,
   output logic [1:0]         rsp_print_kind,
   output logic signed [31:0] rsp_print_value,
   output logic [2:0]         rsp_status,
   input  logic               csr_write_en,
   input  logic [31:0]        csr_write_data
);

   state_type   state_ff, state_in;
   wb_type      wb_ff, wb_in, ex_wb;
   logic [31:0] instr_ff, tin_ff;
   logic [31:0] pc_ff, hi_ff, lo_ff;
   logic [2:0]  halted_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_pc_ff, rsp_pval_ff;
   logic [1:0]  rsp_kind_ff;
   logic [2:0]  rsp_st_ff;

   logic        accept, wb_go, clr_busy;
   logic [31:0] rs_data, rt_data, dmem_rdata;
   logic        dmem_re, div_start;
   div_out_type div_res;

   // Decode of the held instruction.
   logic [5:0]  op, fn;
   logic [4:0]  rs_a, rt_a, rd_a, sh;
   logic [31:0] uimm, simm, pc4, addr, offs;
   logic signed [63:0] prod;
   logic        ex_load, ex_div;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !clr_busy;
   assign wb_go     = !rsp_valid_ff || rsp_ready;

   mse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_instr_word[25:21]),
      .rd_addr_b (req_instr_word[20:16]),
      .rd_data_a (rs_data),
      .rd_data_b (rt_data),
      .wr_en     ((state_ff == S_WB) && wb_go && wb_ff.reg_we),
      .wr_addr   (wb_ff.reg_addr),
      .wr_data   (wb_ff.reg_data)
   );

   mse_dmem u_dmem (
      .clock    (clock),
      .reset    (reset),
      .clr_busy (clr_busy),
      .rd_en    (dmem_re),
      .rd_idx   (ex_wb.mem_idx),
      .rd_data  (dmem_rdata),
      .wr_en    ((state_ff == S_WB) && wb_go && wb_ff.mem_we),
      .wr_idx   (wb_ff.mem_idx),
      .wr_data  (wb_ff.mem_data)
   );

   mse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rs_data),
      .divisor  (rt_data),
      .result   (div_res)
   );

   assign op   = instr_ff[31:26];
   assign rs_a = instr_ff[25:21];
   assign rt_a = instr_ff[20:16];
   assign rd_a = instr_ff[15:11];
   assign sh   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign uimm = {16'd0, instr_ff[15:0]};
   assign simm = {{16{instr_ff[15]}}, instr_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;
   assign addr = rs_data + simm;
   assign offs = addr - DATA_BASE;
   assign prod = $signed(rs_data) * $signed(rt_data);

   // Execute: work out every effect of the instruction into a writeback record.
   always_comb begin
      ex_wb          = '0;
      ex_wb.pc       = pc4;
      ex_wb.kind     = KIND_NONE;
      ex_wb.st       = STAT_RUN;
      ex_wb.hi       = hi_ff;
      ex_wb.lo       = lo_ff;
      ex_wb.mem_data = rt_data;
      ex_wb.mem_idx  = offs[ADDR_W+1:2];
      ex_load        = 1'b0;
      ex_div         = 1'b0;
      unique case (op)
         OP_SPECIAL: begin
            ex_wb.reg_addr = rd_a;
            unique case (fn)
               FN_SLL: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = rt_data << sh;
               end
               FN_SRA: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = 32'($signed(rt_data) >>> sh);
               end
               FN_JR: ex_wb.pc = rs_data;
               FN_MFHI: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = hi_ff;
               end
               FN_MFLO: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = lo_ff;
               end
               FN_MULT: begin
                  ex_wb.hilo_we = 1'b1;
                  ex_wb.hi      = prod[63:32];
                  ex_wb.lo      = prod[31:0];
               end
               FN_DIV: begin
                  if (rt_data == 32'd0) ex_wb.st = STAT_DIVZ;
                  else ex_div = 1'b1;
               end
               FN_ADDU: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = rs_data + rt_data;
               end
               FN_SUBU: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = rs_data - rt_data;
               end
               FN_SLT: begin
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = {31'd0, $signed(rs_data) < $signed(rt_data)};
               end
               default: ex_wb.st = STAT_BADI;
            endcase
         end
         OP_J: ex_wb.pc = (pc4 & JUMP_MASK) + {4'd0, instr_ff[25:0], 2'b00};
         OP_JAL: begin
            ex_wb.reg_we   = 1'b1;
            ex_wb.reg_addr = REG_RA;
            ex_wb.reg_data = pc4;
            ex_wb.pc       = (pc4 & JUMP_MASK) + {4'd0, instr_ff[25:0], 2'b00};
         end
         OP_BEQ: if (rs_data == rt_data) ex_wb.pc = pc4 + {simm[29:0], 2'b00};
         OP_BNE: if (rs_data != rt_data) ex_wb.pc = pc4 + {simm[29:0], 2'b00};
         OP_ADDIU: begin
            ex_wb.reg_we   = 1'b1;
            ex_wb.reg_addr = rt_a;
            ex_wb.reg_data = rs_data + simm;
         end
         OP_ANDI: begin
            ex_wb.reg_we   = 1'b1;
            ex_wb.reg_addr = rt_a;
            ex_wb.reg_data = rs_data & uimm;
         end
         OP_LUI: begin
            ex_wb.reg_we   = 1'b1;
            ex_wb.reg_addr = rt_a;
            ex_wb.reg_data = {instr_ff[15:0], 16'd0};
         end
         OP_TRAP: begin
            ex_wb.reg_addr = rt_a;
            unique case (instr_ff[3:0])
               TRAP_NEWLINE: ex_wb.kind = KIND_NEWLINE;
               TRAP_PRINT: begin
                  ex_wb.kind = KIND_VALUE;
                  ex_wb.pval = rs_data;
               end
               TRAP_READ: begin
                  ex_wb.kind     = KIND_PROMPT;
                  ex_wb.reg_we   = 1'b1;
                  ex_wb.reg_data = tin_ff;
               end
               TRAP_HALT: ex_wb.st = STAT_HALT;
               default: ex_wb.st = STAT_BADT;
            endcase
         end
         OP_LW, OP_SW: begin
            ex_wb.reg_addr = rt_a;
            if (addr[1:0] != 2'b00) ex_wb.st = STAT_UNAL;
            else if (offs >= DATA_BYTES) ex_wb.st = STAT_RANGE;
            else if (op == OP_LW) begin
               ex_wb.reg_we = 1'b1;
               ex_load      = 1'b1;
            end else ex_wb.mem_we = 1'b1;
         end
         default: ex_wb.st = STAT_BADI;
      endcase
      // A halting instruction changes nothing but the pc and the status.
      if (ex_wb.st != STAT_RUN) begin
         ex_wb.reg_we  = 1'b0;
         ex_wb.hilo_we = 1'b0;
         ex_wb.mem_we  = 1'b0;
         ex_wb.pc      = pc4;
         ex_load       = 1'b0;
         ex_div        = 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wb_in     = wb_ff;
      dmem_re   = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (halted_ff != STAT_RUN) begin
                  wb_in      = '0;
                  wb_in.pc   = pc_ff;
                  wb_in.kind = KIND_NONE;
                  wb_in.st   = halted_ff;
                  state_in   = S_WB;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            wb_in = ex_wb;
            if (ex_load) begin
               dmem_re  = 1'b1;
               state_in = S_MEM;
            end else if (ex_div) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_WB;
            end
         end
         S_MEM: begin
            wb_in.reg_data = dmem_rdata;
            state_in       = S_WB;
         end
         S_DIV: begin
            if (div_res.done) begin
               wb_in.hilo_we = 1'b1;
               wb_in.hi      = div_res.rem;
               wb_in.lo      = div_res.quot;
               state_in      = S_WB;
            end
         end
         S_WB: begin
            if (wb_go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_ff <= wb_in;
      if (accept) begin
         instr_ff <= req_instr_word;
         tin_ff   <= req_trap_input;
      end
      if ((state_ff == S_WB) && wb_go) begin
         rsp_pc_ff   <= wb_ff.pc;
         rsp_kind_ff <= wb_ff.kind;
         rsp_pval_ff <= wb_ff.pval;
         rsp_st_ff   <= wb_ff.st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= START_PC_RST;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
         halted_ff    <= STAT_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            pc_ff <= csr_write_data;
         end
         if ((state_ff == S_WB) && wb_go) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= wb_ff.pc;
            halted_ff    <= wb_ff.st;
            if (wb_ff.hilo_we) begin
               hi_ff <= wb_ff.hi;
               lo_ff <= wb_ff.lo;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_print_kind  = rsp_kind_ff;
   assign rsp_print_value = rsp_pval_ff;
   assign rsp_status      = rsp_st_ff;

   `MSE_ASSERT(a_one_at_a_time, accept |=> !req_ready, "item accepted while one is in flight")
   `MSE_ASSERT(a_no_write_halted, ((state_ff == S_WB) && (wb_ff.reg_we || wb_ff.mem_we)) |-> (halted_ff == STAT_RUN), "state written while halted")
   `MSE_ASSERT(a_div_holds_input, (state_ff == S_DIV) |-> !req_ready, "input taken during divide")
   `MSE_ASSERT_ALWAYS(a_clear_blocks, clr_busy |-> !req_ready, "input taken during memory clear")

endmodule

// ----- rtl/mse_regfile.sv -----
// Register file: 32 x 32 memory with two registered read ports and one write port.
// Depends on mse_pkg. Entries not written since reset read as their reset value.
module mse_regfile import mse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] mem_a_ff, mem_b_ff;
   logic        vld_a_ff, vld_b_ff;
   logic [4:0]  addr_a_ff, addr_b_ff;

   function automatic logic [31:0] reset_value(input logic [4:0] addr);
      logic [31:0] v;
      v = 32'd0;
      if (addr == REG_GP) v = GP_INIT;
      if (addr == REG_SP) v = SP_INIT;
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr != 5'd0)) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_a_ff  <= mem[rd_addr_a];
         mem_b_ff  <= mem[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 32'd0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (wr_en && (wr_addr != 5'd0)) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_a_ff <= valid_ff[rd_addr_a];
            vld_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = vld_a_ff ? mem_a_ff : reset_value(addr_a_ff);
   assign rd_data_b = vld_b_ff ? mem_b_ff : reset_value(addr_b_ff);

endmodule

// ----- rtl/mse_dmem.sv -----
// Data memory: DATA_WORDS x 32, one write and one registered read port.
// Depends on mse_pkg. After reset a sweep writes zero to every word.
module mse_dmem import mse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   output logic              clr_busy,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_idx,
   output logic [31:0]       rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_idx,
   input  logic [31:0]       wr_data
);

   logic [31:0]       mem [DATA_WORDS];
   logic              busy_ff;
   logic [ADDR_W-1:0] clr_idx_ff;
   logic [31:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == ADDR_W'(DATA_WORDS - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= 32'd0;
      end else if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign clr_busy = busy_ff;
   assign rd_data  = rd_data_ff;

endmodule

// ----- rtl/mse_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, 32 steps.
// Depends on mse_pkg for the result struct.
module mse_divider import mse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output div_out_type result
);

   logic        run_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic        neg_q_ff, neg_r_ff;
   logic [32:0] shifted;
   logic [33:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 5'd31);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 5'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) run_ff <= 1'b0;
         end
      end
   end

   // Magnitudes are divided; signs are applied at the end.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff   <= dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_ff   <= divisor[31] ? (32'd0 - divisor) : divisor;
         rem_ff   <= 32'd0;
         neg_q_ff <= dividend[31] ^ divisor[31];
         neg_r_ff <= dividend[31];
      end else if (run_ff) begin
         if (!diff[33]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign result.done = done_ff;
   assign result.quot = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
   assign result.rem  = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;

endmodule

// ----- bench/mips_subset_execute_tb.sv -----
// Self-checking testbench for mips_subset_execute: a directed stimulus table, then phases of
// random well-formed programs under several start_pc values, then one halting item and items after it.
// Depends on mse_pkg and the mips_subset_execute RTL.
module mips_subset_execute_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mse_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  kind;
      logic [31:0] pval;
      logic [2:0]  st;
   } result_type;

   typedef struct {
      logic [31:0] ins;
      logic [31:0] tin;
      bit          typed;
      result_type  res;
   } stim_row_type;

   localparam result_type UNTYPED = '{32'd0, KIND_NONE, 32'd0, STAT_RUN};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_instr_word = '0;
   logic signed [31:0] req_trap_input = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_next_pc;
   logic [1:0]         rsp_print_kind;
   logic signed [31:0] rsp_print_value;
   logic [2:0]         rsp_status;
   logic               csr_write_en = 1'b0;
   logic [31:0]        csr_write_data = '0;

   // Shadow state of the executor.
   logic [31:0] m_regs [32];
   logic [31:0] m_hi, m_lo, m_pc;
   logic [2:0]  m_halted;
   logic [31:0] m_mem [int];

   result_type   pending_results [$];
   stim_row_type directed [$];
   int           n_sent = 0;
   int           n_recv = 0;
   int           errors = 0;

   mips_subset_execute i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_instr_word  (req_instr_word),
      .req_trap_input  (req_trap_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_print_kind  (rsp_print_kind),
      .rsp_print_value (rsp_print_value),
      .rsp_status      (rsp_status),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] enc_r(int rs, int rt, int rd, int sh, logic [5:0] fn);
      return {OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, int rs, int rt, logic [15:0] imm);
      return {op, 5'(rs), 5'(rt), imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   function automatic logic [31:0] enc_trap(int rs, int rt, logic [3:0] code, logic [11:0] junk);
      return {OP_TRAP, 5'(rs), 5'(rt), junk, code};
   endfunction

   function automatic void set_reg(logic [4:0] n, logic [31:0] v);
      if (n != 5'd0) m_regs[n] = v;
   endfunction

   function automatic logic [2:0] data_addr_status(logic [31:0] addr);
      if (addr[1:0] != 2'b00) return STAT_UNAL;
      if (addr - DATA_BASE >= DATA_BYTES) return STAT_RANGE;
      return STAT_RUN;
   endfunction

   function automatic void reset_executor();
      foreach (m_regs[i]) m_regs[i] = '0;
      m_regs[REG_GP] = GP_INIT;
      m_regs[REG_SP] = SP_INIT;
      m_hi = '0;
      m_lo = '0;
      m_pc = START_PC_RST;
      m_halted = STAT_RUN;
      m_mem.delete();
   endfunction

   // Executes one instruction against the shadow state and returns its result item.
   function automatic result_type execute_instr(logic [31:0] ins, logic [31:0] tin);
      result_type  r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh;
      logic [31:0] a, b, simm, uimm, npc, addr;
      logic signed [63:0] prod;
      int          idx;
      if (m_halted != STAT_RUN) begin
         r = '{m_pc, KIND_NONE, 32'd0, m_halted};
         return r;
      end
      op = ins[31:26];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      sh = ins[10:6];
      fn = ins[5:0];
      uimm = {16'd0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      a = m_regs[rs];
      b = m_regs[rt];
      npc = m_pc + 32'd4;
      r = '{32'd0, KIND_NONE, 32'd0, STAT_RUN};
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL:  set_reg(rd, b << sh);
               FN_SRA:  set_reg(rd, $signed(b) >>> sh);
               FN_JR:   npc = a;
               FN_MFHI: set_reg(rd, m_hi);
               FN_MFLO: set_reg(rd, m_lo);
               FN_MULT: begin
                  prod = $signed(a) * $signed(b);
                  m_lo = prod[31:0];
                  m_hi = prod[63:32];
               end
               FN_DIV: begin
                  if (b == 32'd0) begin
                     r.st = STAT_DIVZ;
                  end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
                     m_lo = 32'h8000_0000;
                     m_hi = '0;
                  end else begin
                     m_lo = $signed(a) / $signed(b);
                     m_hi = $signed(a) % $signed(b);
                  end
               end
               FN_ADDU: set_reg(rd, a + b);
               FN_SUBU: set_reg(rd, a - b);
               FN_SLT:  set_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
               default: r.st = STAT_BADI;
            endcase
         end
         OP_J:   npc = (npc & JUMP_MASK) + {4'd0, ins[25:0], 2'b00};
         OP_JAL: begin
            set_reg(REG_RA, npc);
            npc = (npc & JUMP_MASK) + {4'd0, ins[25:0], 2'b00};
         end
         OP_BEQ:   if (a == b) npc = npc + (simm << 2);
         OP_BNE:   if (a != b) npc = npc + (simm << 2);
         OP_ADDIU: set_reg(rt, a + simm);
         OP_ANDI:  set_reg(rt, a & uimm);
         OP_LUI:   set_reg(rt, uimm << 16);
         OP_TRAP: begin
            case (ins[3:0])
               TRAP_NEWLINE: r.kind = KIND_NEWLINE;
               TRAP_PRINT: begin
                  r.kind = KIND_VALUE;
                  r.pval = a;
               end
               TRAP_READ: begin
                  r.kind = KIND_PROMPT;
                  set_reg(rt, tin);
               end
               TRAP_HALT: r.st = STAT_HALT;
               default:   r.st = STAT_BADT;
            endcase
         end
         OP_LW, OP_SW: begin
            addr = a + simm;
            r.st = data_addr_status(addr);
            idx = int'((addr - DATA_BASE) >> 2);
            if (r.st == STAT_RUN) begin
               if (op == OP_SW) m_mem[idx] = b;
               else set_reg(rt, m_mem.exists(idx) ? m_mem[idx] : 32'd0);
            end
         end
         default: r.st = STAT_BADI;
      endcase
      m_pc = npc;
      m_halted = r.st;
      r.next_pc = npc;
      return r;
   endfunction

   // Destinations avoid gp and sp so that the random loads and stores keep a valid base.
   function automatic int pick_dest();
      int d;
      do d = $urandom_range(0, 31); while (d == REG_GP || d == REG_SP);
      return d;
   endfunction

   // Draws a random instruction that does not halt, given the current shadow registers.
   function automatic logic [31:0] random_instr();
      int          rs, src2, rd, sh;
      logic [15:0] imm;
      logic [31:0] ins;
      rs = $urandom_range(0, 31);
      src2 = $urandom_range(0, 31);
      rd = pick_dest();
      sh = $urandom_range(0, 31);
      imm = 16'($urandom);
      case ($urandom_range(0, 19))
         0:  ins = enc_r(rs, src2, rd, sh, FN_SLL);
         1:  ins = enc_r(rs, src2, rd, sh, FN_SRA);
         2:  ins = enc_r(rs, src2, rd, sh, FN_JR);
         3:  ins = enc_r(rs, src2, rd, sh, FN_MFHI);
         4:  ins = enc_r(rs, src2, rd, sh, FN_MFLO);
         5:  ins = enc_r(rs, src2, rd, sh, FN_MULT);
         6:  ins = enc_r(rs, src2, rd, sh, (m_regs[src2] == 32'd0) ? FN_MULT : FN_DIV);
         7:  ins = enc_r(rs, src2, rd, sh, FN_ADDU);
         8:  ins = enc_r(rs, src2, rd, sh, FN_SUBU);
         9:  ins = enc_r(rs, src2, rd, sh, FN_SLT);
         10: ins = enc_j(OP_J, 26'($urandom));
         11: ins = enc_j(OP_JAL, 26'($urandom));
         12: ins = enc_i(OP_BEQ, rs, ($urandom_range(0, 3) == 0) ? rs : src2, imm);
         13: ins = enc_i(OP_BNE, rs, ($urandom_range(0, 3) == 0) ? rs : src2, imm);
         14: ins = enc_i(OP_ADDIU, rs, rd, imm);
         15: ins = enc_i(OP_ANDI, rs, rd, imm);
         16: ins = enc_i(OP_LUI, rs, rd, imm);
         17, 18: begin
            // Mostly a small window around gp, so that loads find earlier stores.
            if ($urandom_range(0, 3) != 0 ||
                data_addr_status(m_regs[rs] + {{16{imm[15]}}, imm}) != STAT_RUN) begin
               rs = REG_GP;
               imm = 16'(4 * $urandom_range(0, 31) - 64);
            end
            // A load writes its rt, so it takes a safe destination; a store may read any.
            if ($urandom_range(0, 1) == 0) ins = enc_i(OP_LW, rs, rd, imm);
            else ins = enc_i(OP_SW, rs, ($urandom_range(0, 1) == 0) ? rd : src2, imm);
         end
         default: begin
            case ($urandom_range(0, 2))
               0:       ins = enc_trap(rs, rd, TRAP_NEWLINE, 12'($urandom));
               1:       ins = enc_trap(rs, rd, TRAP_PRINT, 12'($urandom));
               default: ins = enc_trap(rs, rd, TRAP_READ, 12'($urandom));
            endcase
         end
      endcase
      return ins;
   endfunction

   task automatic send_item(logic [31:0] ins, logic [31:0] tin, bit typed, result_type given);
      int         gap;
      result_type predicted;
      gap = ((n_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_instr_word <= ins;
      req_trap_input <= tin;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = execute_instr(ins, tin);
      pending_results.push_back(typed ? given : predicted);
      n_sent++;
      @(negedge clock);
   endtask

   // The register is only written once every expected item has come back.
   task automatic write_start_pc(logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      m_pc = value;
   endtask

   initial begin
      logic [31:0] phase_pc [5];
      reset_executor();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back('{enc_i(OP_ADDIU, 0, 8, 16'h7fff), 32'd0, 1'b1,
                           '{32'h0040_0004, KIND_NONE, 32'd0, STAT_RUN}});
      directed.push_back('{enc_trap(0, 0, TRAP_NEWLINE, 12'd0), 32'd0, 1'b1,
                           '{32'h0040_0008, KIND_NEWLINE, 32'd0, STAT_RUN}});
      directed.push_back('{enc_trap(8, 0, TRAP_PRINT, 12'hfff), 32'hffff_ffff, 1'b1,
                           '{32'h0040_000c, KIND_VALUE, 32'h0000_7fff, STAT_RUN}});
      directed.push_back('{enc_trap(0, 21, TRAP_READ, 12'd0), 32'h8000_0000, 1'b1,
                           '{32'h0040_0010, KIND_PROMPT, 32'd0, STAT_RUN}});
      directed.push_back('{enc_i(OP_ADDIU, 0, 9, 16'h8000), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_LUI, 0, 10, 16'hffff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_ANDI, 10, 11, 16'hffff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(8, 9, 12, 0, FN_ADDU), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(9, 8, 13, 31, FN_SUBU), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(9, 8, 14, 0, FN_SLT), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(0, 9, 15, 31, FN_SLL), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(0, 9, 16, 31, FN_SRA), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(9, 9, 0, 0, FN_MULT), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(0, 0, 18, 0, FN_MFHI), 32'd0, 1'b0, UNTYPED});
      // The most negative value divided by minus one.
      directed.push_back('{enc_i(OP_LUI, 0, 20, 16'h8000), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_ADDIU, 0, 22, 16'hffff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(20, 22, 0, 0, FN_DIV), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(0, 0, 24, 0, FN_MFLO), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(9, 8, 0, 0, FN_DIV), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_SW, REG_GP, 9, 16'h8000), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_SW, REG_SP, 21, 16'hfffc), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_LW, REG_GP, 25, 16'h8000), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_ADDIU, 8, 0, 16'h0005), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_BEQ, 0, 0, 16'hffff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_i(OP_BNE, 8, 0, 16'h7fff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_j(OP_J, 26'h3ff_ffff), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_j(OP_JAL, 26'd0), 32'd0, 1'b0, UNTYPED});
      directed.push_back('{enc_r(9, 0, 0, 0, FN_JR), 32'd0, 1'b0, UNTYPED});
      foreach (directed[i]) send_item(directed[i].ins, directed[i].tin, directed[i].typed,
                                      directed[i].res);

      phase_pc = '{32'h0000_0000, 32'hffff_ffff, START_PC_RST, $urandom, 32'hffff_fffc};
      foreach (phase_pc[p]) begin
         write_start_pc(phase_pc[p]);
         repeat (80) send_item(random_instr(), $urandom, 1'b0, UNTYPED);
      end

      // One halting item closes the program; the block then repeats its status.
      case ($urandom_range(0, 6))
         0: send_item(enc_trap(0, 0, TRAP_HALT, 12'($urandom)), $urandom, 1'b0, UNTYPED);
         1: send_item(enc_r($urandom_range(0, 31), 0, 1, 0, FN_DIV), $urandom, 1'b0, UNTYPED);
         2: send_item({6'h3f, 26'($urandom)}, $urandom, 1'b0, UNTYPED);
         3: send_item(enc_r(1, 2, 3, 0, 6'h01), $urandom, 1'b0, UNTYPED);
         4: send_item(enc_trap(1, 2, 4'h3, 12'($urandom)), $urandom, 1'b0, UNTYPED);
         5: send_item(enc_i(OP_LW, REG_GP, 1, 16'h0001), $urandom, 1'b0, UNTYPED);
         default: send_item(enc_i(OP_SW, REG_SP, 1, 16'h0000), $urandom, 1'b0, UNTYPED);
      endcase
      repeat (4) send_item($urandom, $urandom, 1'b0, UNTYPED);
      write_start_pc($urandom);
      repeat (3) send_item($urandom, $urandom, 1'b0, UNTYPED);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (pending_results.size() != 0) errors++;
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that backs up the input.
   initial begin
      int         stall;
      result_type want;
      result_type got;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ((n_recv / 50) % 4 == 1) ? 0 : $urandom_range(0, 11);
         if (n_recv == 120) stall = 400;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_next_pc, rsp_print_kind, rsp_print_value, rsp_status};
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result item: pc %h", got.next_pc);
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch at result %0d: pc %h/%h kind %0d/%0d value %h/%h st %0d/%0d",
                           n_recv, want.next_pc, got.next_pc, want.kind, got.kind,
                           want.pval, got.pval, want.st, got.st);
            end
         end
         n_recv++;
         @(negedge clock);
      end
   end

   // Ends the run when no item moves on either channel for too long.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
